// ----- rtl/segx_pkg.sv -----
// shared types, widths and status codes for the segment intersection block
`default_nettype none
package segx_pkg;
   localparam int COORD_W = 16;
   localparam int DELTA_W = COORD_W + 1;
   localparam int PROD_W  = 2 * DELTA_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = CROSS_W - 1;
   localparam int DMAG_W  = COORD_W;
   localparam int WIDE_W  = MAG_W + DMAG_W;
   localparam int Q_W     = DMAG_W;
   localparam int NCELLS  = Q_W;

   localparam logic [1:0] STATUS_HIT      = 2'd0;
   localparam logic [1:0] STATUS_PARALLEL = 2'd1;
   localparam logic [1:0] STATUS_MISS     = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_start_x;
      logic signed [COORD_W-1:0] a_start_y;
      logic signed [COORD_W-1:0] a_end_x;
      logic signed [COORD_W-1:0] a_end_y;
      logic signed [COORD_W-1:0] b_start_x;
      logic signed [COORD_W-1:0] b_start_y;
      logic signed [COORD_W-1:0] b_end_x;
      logic signed [COORD_W-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic [1:0]                hit_status;
      logic signed [COORD_W-1:0] hit_x;
      logic signed [COORD_W-1:0] hit_y;
   } rsp_type;

   // word handed from one divider cell to the next
   typedef struct packed {
      logic                      valid;
      logic [1:0]                status;
      logic                      neg_x;
      logic                      neg_y;
      logic [COORD_W-1:0]        xa0;
      logic [COORD_W-1:0]        ya0;
      logic [WIDE_W-1:0]         rem_x;
      logic [WIDE_W-1:0]         rem_y;
      logic [WIDE_W-1:0]         dvs;
      logic [Q_W-1:0]            qx;
      logic [Q_W-1:0]            qy;
   } segx_cell_type;
endpackage
`default_nettype wire

// ----- rtl/segment_intersection.sv -----
// pipeline: 5 front stages, one divider cell per quotient bit (16 cells) and an output register
// throughput: one word per cycle while the output is not stalled; the front stages and the cell chain move in lockstep
// the whole pipeline holds only while the output register is full and stalled
// reset: synchronous, clears all stage valid bits and the output valid; data is not cleared
`default_nettype none
module segment_intersection
   import segx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   // pipeline advances when the output register is empty or being taken
   logic          adv;
   segx_cell_type chain [0:NCELLS];
   segx_cell_type last;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;
   logic [COORD_W-1:0] qx_w, qy_w;

   assign adv       = !out_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // deltas, cross products, unit-interval test, scaled numerators
   segx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_word (chain[0])
   );

   // row of divider cells, msb of the quotient first
   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      segx_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .in_word (chain[i]),
         .out_ff  (chain[i+1])
      );
   end

   assign last = chain[NCELLS];

   // apply the sign and offset from the start point, zero unless a hit
   always_comb begin
      qx_w = COORD_W'(last.qx);
      qy_w = COORD_W'(last.qy);
      out_valid_in      = last.valid;
      out_in.hit_status = last.status;
      if (last.status == STATUS_HIT) begin
         out_in.hit_x = last.xa0 + (last.neg_x ? -qx_w : qx_w);
         out_in.hit_y = last.ya0 + (last.neg_y ? -qy_w : qy_w);
      end else begin
         out_in.hit_x = '0;
         out_in.hit_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (adv)
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (adv)
         out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // status is one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit_status == STATUS_HIT ||
                     rsp_data.hit_status == STATUS_PARALLEL ||
                     rsp_data.hit_status == STATUS_MISS))
      else $error("undefined hit status");

   // no point is reported without a hit
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit_status != STATUS_HIT) |->
         (rsp_data.hit_x == '0 && rsp_data.hit_y == '0))
      else $error("point nonzero without a hit");

   // input only held back by a full, stalled output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");
endmodule
`default_nettype wire

// ----- rtl/segx_front.sv -----
// front pipeline: deltas, cross products, range test, scaled numerators
`default_nettype none
module segx_front
   import segx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire req_type       in_data,
   output segx_cell_type      out_word
);
   // stage 1
   logic                      v1_ff;
   logic signed [DELTA_W-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff, ex_ff, ey_ff;
   logic [COORD_W-1:0]        xa1_ff, ya1_ff;
   // stage 2
   logic                      v2_ff;
   logic signed [PROD_W-1:0]  p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [DELTA_W-1:0] dxa2_ff, dya2_ff;
   logic [COORD_W-1:0]        xa2_ff, ya2_ff;
   // stage 3
   logic                      v3_ff;
   logic signed [CROSS_W-1:0] den_ff, na_ff, nb_ff;
   logic signed [DELTA_W-1:0] dxa3_ff, dya3_ff;
   logic [COORD_W-1:0]        xa3_ff, ya3_ff;
   // stage 4
   logic                      v4_ff;
   logic [1:0]                st4_ff;
   logic                      nx4_ff, ny4_ff;
   logic [MAG_W-1:0]          mna_ff, mden_ff;
   logic [DMAG_W-1:0]         mdx_ff, mdy_ff;
   logic [COORD_W-1:0]        xa4_ff, ya4_ff;
   // stage 5
   logic                      v5_ff;
   logic [1:0]                st5_ff;
   logic                      nx5_ff, ny5_ff;
   logic [WIDE_W-1:0]         wx_ff, wy_ff;
   logic [MAG_W-1:0]          mden5_ff;
   logic [COORD_W-1:0]        xa5_ff, ya5_ff;

   logic                      in_a, in_b;
   logic [1:0]                st4_in;
   logic signed [CROSS_W-1:0] neg_na, neg_den;
   logic signed [DELTA_W-1:0] neg_dx, neg_dy;

   function automatic logic signed [DELTA_W-1:0] sx(input logic [COORD_W-1:0] v);
      return $signed({v[COORD_W-1], v});
   endfunction

   function automatic logic unit_test(input logic signed [CROSS_W-1:0] n,
                                      input logic signed [CROSS_W-1:0] d);
      if (!d[CROSS_W-1])
         return !n[CROSS_W-1] && (n <= d);
      return (n == '0) || (n[CROSS_W-1] && (n >= d));
   endfunction

   always_comb begin
      in_a    = unit_test(na_ff, den_ff);
      in_b    = unit_test(nb_ff, den_ff);
      neg_na  = -na_ff;
      neg_den = -den_ff;
      neg_dx  = -dxa3_ff;
      neg_dy  = -dya3_ff;
      if (den_ff == '0)
         st4_in = STATUS_PARALLEL;
      else if (in_a && in_b)
         st4_in = STATUS_HIT;
      else
         st4_in = STATUS_MISS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dxa_ff <= sx(in_data.a_end_x) - sx(in_data.a_start_x);
         dya_ff <= sx(in_data.a_end_y) - sx(in_data.a_start_y);
         dxb_ff <= sx(in_data.b_end_x) - sx(in_data.b_start_x);
         dyb_ff <= sx(in_data.b_end_y) - sx(in_data.b_start_y);
         ex_ff  <= sx(in_data.a_start_x) - sx(in_data.b_start_x);
         ey_ff  <= sx(in_data.a_start_y) - sx(in_data.b_start_y);
         xa1_ff <= in_data.a_start_x;
         ya1_ff <= in_data.a_start_y;

         p0_ff   <= dyb_ff * dxa_ff;
         p1_ff   <= dxb_ff * dya_ff;
         p2_ff   <= dxb_ff * ey_ff;
         p3_ff   <= dyb_ff * ex_ff;
         p4_ff   <= dxa_ff * ey_ff;
         p5_ff   <= dya_ff * ex_ff;
         dxa2_ff <= dxa_ff;
         dya2_ff <= dya_ff;
         xa2_ff  <= xa1_ff;
         ya2_ff  <= ya1_ff;

         den_ff  <= CROSS_W'(p0_ff) - CROSS_W'(p1_ff);
         na_ff   <= CROSS_W'(p2_ff) - CROSS_W'(p3_ff);
         nb_ff   <= CROSS_W'(p4_ff) - CROSS_W'(p5_ff);
         dxa3_ff <= dxa2_ff;
         dya3_ff <= dya2_ff;
         xa3_ff  <= xa2_ff;
         ya3_ff  <= ya2_ff;

         st4_ff  <= st4_in;
         nx4_ff  <= na_ff[CROSS_W-1] ^ dxa3_ff[DELTA_W-1] ^ den_ff[CROSS_W-1];
         ny4_ff  <= na_ff[CROSS_W-1] ^ dya3_ff[DELTA_W-1] ^ den_ff[CROSS_W-1];
         mna_ff  <= na_ff[CROSS_W-1] ? neg_na[MAG_W-1:0] : na_ff[MAG_W-1:0];
         mden_ff <= den_ff[CROSS_W-1] ? neg_den[MAG_W-1:0] : den_ff[MAG_W-1:0];
         mdx_ff  <= dxa3_ff[DELTA_W-1] ? neg_dx[DMAG_W-1:0] : dxa3_ff[DMAG_W-1:0];
         mdy_ff  <= dya3_ff[DELTA_W-1] ? neg_dy[DMAG_W-1:0] : dya3_ff[DMAG_W-1:0];
         xa4_ff  <= xa3_ff;
         ya4_ff  <= ya3_ff;

         st5_ff   <= st4_ff;
         nx5_ff   <= nx4_ff;
         ny5_ff   <= ny4_ff;
         wx_ff    <= WIDE_W'(mna_ff) * WIDE_W'(mdx_ff);
         wy_ff    <= WIDE_W'(mna_ff) * WIDE_W'(mdy_ff);
         mden5_ff <= mden_ff;
         xa5_ff   <= xa4_ff;
         ya5_ff   <= ya4_ff;
      end
   end

   always_comb begin
      out_word.valid  = v5_ff;
      out_word.status = st5_ff;
      out_word.neg_x  = nx5_ff;
      out_word.neg_y  = ny5_ff;
      out_word.xa0    = xa5_ff;
      out_word.ya0    = ya5_ff;
      out_word.rem_x  = wx_ff;
      out_word.rem_y  = wy_ff;
      out_word.dvs    = WIDE_W'({mden5_ff, {(Q_W-1){1'b0}}});
      out_word.qx     = '0;
      out_word.qy     = '0;
   end
endmodule
`default_nettype wire

// ----- rtl/segx_div_cell.sv -----
// one restoring divider cell: one quotient bit for x and y
`default_nettype none
module segx_div_cell
   import segx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire segx_cell_type in_word,
   output segx_cell_type      out_ff
);
   segx_cell_type out_in;
   logic          gx, gy;

   always_comb begin
      gx     = in_word.rem_x >= in_word.dvs;
      gy     = in_word.rem_y >= in_word.dvs;
      out_in = in_word;
      out_in.rem_x = gx ? in_word.rem_x - in_word.dvs : in_word.rem_x;
      out_in.rem_y = gy ? in_word.rem_y - in_word.dvs : in_word.rem_y;
      out_in.qx    = {in_word.qx[Q_W-2:0], gx};
      out_in.qy    = {in_word.qy[Q_W-2:0], gy};
      out_in.dvs   = in_word.dvs >> 1;
   end

   // only the valid bit is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         out_ff.status <= out_in.status;
         out_ff.neg_x  <= out_in.neg_x;
         out_ff.neg_y  <= out_in.neg_y;
         out_ff.xa0    <= out_in.xa0;
         out_ff.ya0    <= out_in.ya0;
         out_ff.rem_x  <= out_in.rem_x;
         out_ff.rem_y  <= out_in.rem_y;
         out_ff.dvs    <= out_in.dvs;
         out_ff.qx     <= out_in.qx;
         out_ff.qy     <= out_in.qy;
      end
   end
endmodule
`default_nettype wire
